FILE: sv/postfix_atom_record_filter_assert.svh
// ---------------------------------------------------------------------------
// postfix_atom_record_filter assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_ATOM_RECORD_FILTER_ASSERT_SVH
`define POSTFIX_ATOM_RECORD_FILTER_ASSERT_SVH

// property must hold at every edge out of reset
`define PARF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define PARF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/parf_pkg.sv
// ---------------------------------------------------------------------------
// parf_pkg
// Shared types, codes and sizes of the postfix atom record filter.
// ---------------------------------------------------------------------------
package parf_pkg;

  localparam int PROGRAM_DEPTH = 32;
  localparam int STACK_DEPTH   = 32;

  localparam int PW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int LW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);

  localparam int IN_W   = 248;
  localparam int OUT_W  = 8;
  localparam int USER_W = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [5:0] K_TRUE      = 6'd0;
  localparam logic [5:0] K_NAME_EQ   = 6'd1;
  localparam logic [5:0] K_NAME_NE   = 6'd2;
  localparam logic [5:0] K_ELEM_EQ   = 6'd3;
  localparam logic [5:0] K_ELEM_NE   = 6'd4;
  localparam logic [5:0] K_RES_RANGE = 6'd5;
  localparam logic [5:0] K_RES_CMP   = 6'd6;
  localparam logic [5:0] K_OCC_CMP   = 6'd12;
  localparam logic [5:0] K_BFAC_CMP  = 6'd18;
  localparam logic [5:0] K_RESN_EQ   = 6'd24;
  localparam logic [5:0] K_RESN_NE   = 6'd25;
  localparam logic [5:0] K_INS_EQ    = 6'd26;
  localparam logic [5:0] K_INS_NE    = 6'd27;
  localparam logic [5:0] K_ALT_EQ    = 6'd28;
  localparam logic [5:0] K_ALT_NE    = 6'd29;
  localparam logic [5:0] K_CHAIN_EQ  = 6'd30;
  localparam logic [5:0] K_CHAIN_NE  = 6'd31;
  localparam logic [5:0] K_CHNUM_EQ  = 6'd32;
  localparam logic [5:0] K_CHNUM_NE  = 6'd33;
  localparam logic [5:0] K_OR        = 6'd34;
  localparam logic [5:0] K_AND       = 6'd35;
  localparam logic [5:0] K_NOT       = 6'd36;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [5:0]         kind;
    logic [31:0]        text;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic signed [20:0] level;
  } term_t;

  typedef struct packed {
    logic [31:0]        name;
    logic [15:0]        element;
    logic signed [15:0] resi;
    logic signed [20:0] occ;
    logic signed [20:0] bfac;
    logic [47:0]        tags;
  } atom_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;       // overflowed or empty program, no walk
    logic last;       // current term is the last one
    logic step_fault; // current term faults
    logic out_free;   // result register can take a result
  } dp_sts_t;

  // six-way signed compare, sel in 0..5
  function automatic logic cmp6(input logic signed [20:0] a, input logic signed [20:0] b,
                                input logic [2:0] sel);
    logic r;
    case (sel)
      CMP_EQ:  r = (a == b);
      CMP_NE:  r = (a != b);
      CMP_LT:  r = (a < b);
      CMP_LE:  r = (a <= b);
      CMP_GT:  r = (a > b);
      default: r = (a >= b);
    endcase
    return r;
  endfunction

endpackage

FILE: sv/parf_ctrl.sv
// ---------------------------------------------------------------------------
// parf_ctrl
// Sequencer: takes transactions, walks the program, hands off the result.
// ---------------------------------------------------------------------------
module parf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic [1:0]        opcode_i,
  input  parf_pkg::dp_sts_t sts_i,
  output logic              s_tready_o,
  output parf_pkg::dp_cmd_t cmd_o
);
  import parf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && opcode_i == OP_EVAL) begin
          state_d = sts_i.skip ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.last || sts_i.step_fault) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (opcode_i)
            OP_CLEAR:  cmd_o.clear  = 1'b1;
            OP_APPEND: cmd_o.append = 1'b1;
            OP_EVAL:   cmd_o.start  = 1'b1;
            default:   cmd_o        = '0;
          endcase
        end
      end
      ST_RUN:    cmd_o.step   = 1'b1;
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

endmodule

FILE: sv/parf_dp.sv
// ---------------------------------------------------------------------------
// parf_dp
// Program memory, term evaluator, truth stack and result register.
// ---------------------------------------------------------------------------
module parf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  parf_pkg::dp_cmd_t cmd_i,
  input  parf_pkg::term_t   term_i,
  input  parf_pkg::atom_t   atom_i,
  output parf_pkg::dp_sts_t sts_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic              match_o,
  output logic              fault_o
);
  import parf_pkg::*;

  term_t mem [PROGRAM_DEPTH];
  term_t rd_q;
  logic [PW-1:0] rd_addr;

  logic [LW-1:0] len_q;
  logic          ovf_q;
  logic [PW-1:0] pc_q;
  atom_t         atom_q;

  logic [STACK_DEPTH-1:0] stack_q, stack_d;
  logic [SW-1:0]          depth_q, depth_d;
  logic                   fault_q;
  logic                   step_fault;

  logic out_valid_q, match_q, fault_out_q;

  // program memory, registered read
  assign rd_addr = cmd_i.start ? '0 : pc_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && len_q != LW'(PROGRAM_DEPTH)) begin
      mem[len_q[PW-1:0]] <= term_i;
    end
    rd_q <= mem[rd_addr];
  end

  // term evaluation on the word read for pc_q
  logic          res;
  logic          is_pred, is_bin, is_not;
  logic [SW-1:0] d1, d2;
  logic [7:0]    chain, ins, alt;
  logic [23:0]   resn;

  always_comb begin
    chain = atom_q.tags[7:0];
    alt   = atom_q.tags[15:8];
    ins   = atom_q.tags[23:16];
    resn  = atom_q.tags[47:24];
    d1    = depth_q - SW'(1);
    d2    = depth_q - SW'(2);
    res     = 1'b0;
    is_pred = 1'b1;
    is_bin  = 1'b0;
    is_not  = 1'b0;
    if (rd_q.kind == K_TRUE) begin
      res = 1'b1;
    end else if (rd_q.kind <= K_NAME_NE) begin
      res = (atom_q.name == rd_q.text) ^ (rd_q.kind == K_NAME_NE);
    end else if (rd_q.kind <= K_ELEM_NE) begin
      res = ({16'b0, atom_q.element} == rd_q.text) ^ (rd_q.kind == K_ELEM_NE);
    end else if (rd_q.kind == K_RES_RANGE) begin
      res = (atom_q.resi >= rd_q.low) && (atom_q.resi <= rd_q.high);
    end else if (rd_q.kind < K_OCC_CMP) begin
      res = cmp6(21'(atom_q.resi), 21'(rd_q.low), 3'(rd_q.kind - K_RES_CMP));
    end else if (rd_q.kind < K_BFAC_CMP) begin
      res = cmp6(atom_q.occ, rd_q.level, 3'(rd_q.kind - K_OCC_CMP));
    end else if (rd_q.kind < K_RESN_EQ) begin
      res = cmp6(atom_q.bfac, rd_q.level, 3'(rd_q.kind - K_BFAC_CMP));
    end else if (rd_q.kind <= K_RESN_NE) begin
      res = ({8'b0, resn} == rd_q.text) ^ (rd_q.kind == K_RESN_NE);
    end else if (rd_q.kind <= K_INS_NE) begin
      res = ({24'b0, ins} == rd_q.text) ^ (rd_q.kind == K_INS_NE);
    end else if (rd_q.kind <= K_ALT_NE) begin
      res = ({24'b0, alt} == rd_q.text) ^ (rd_q.kind == K_ALT_NE);
    end else if (rd_q.kind <= K_CHAIN_NE) begin
      res = ({24'b0, chain} == rd_q.text) ^ (rd_q.kind == K_CHAIN_NE);
    end else if (rd_q.kind <= K_CHNUM_NE) begin
      res = (rd_q.low >= 16'sd0 && rd_q.low <= 16'sd9 &&
             chain == 8'h30 + rd_q.low[7:0]) ^ (rd_q.kind == K_CHNUM_NE);
    end else begin
      is_pred = 1'b0;
      is_bin  = (rd_q.kind == K_OR) || (rd_q.kind == K_AND);
      is_not  = (rd_q.kind == K_NOT);
    end

    stack_d    = stack_q;
    depth_d    = depth_q;
    step_fault = 1'b0;
    if (is_pred) begin
      if (depth_q == SW'(STACK_DEPTH)) begin
        step_fault = 1'b1;
      end else begin
        stack_d[depth_q[SI-1:0]] = res;
        depth_d = depth_q + SW'(1);
      end
    end else if (is_bin) begin
      if (depth_q < SW'(2)) begin
        step_fault = 1'b1;
      end else begin
        stack_d[d2[SI-1:0]] = (rd_q.kind == K_OR) ?
                              (stack_q[d1[SI-1:0]] | stack_q[d2[SI-1:0]]) :
                              (stack_q[d1[SI-1:0]] & stack_q[d2[SI-1:0]]);
        depth_d = d1;
      end
    end else if (is_not) begin
      if (depth_q == '0) begin
        step_fault = 1'b1;
      end else begin
        stack_d[d1[SI-1:0]] = ~stack_q[d1[SI-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      pc_q    <= '0;
      stack_q <= '0;
      depth_q <= '0;
      fault_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.append) begin
        if (len_q == LW'(PROGRAM_DEPTH)) begin
          ovf_q <= 1'b1;
        end else begin
          len_q <= len_q + LW'(1);
        end
      end
      if (cmd_i.start) begin
        pc_q    <= '0;
        stack_q <= '0;
        depth_q <= '0;
        fault_q <= ovf_q;
      end
      if (cmd_i.step) begin
        pc_q    <= pc_q + 1'b1;
        stack_q <= stack_d;
        depth_q <= depth_d;
        fault_q <= fault_q | step_fault;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      atom_q <= atom_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      match_q     <= !fault_q && (len_q == '0 ||
                     (depth_q != '0 && stack_q[d1[SI-1:0]]));
      fault_out_q <= fault_q || (len_q != '0 && depth_q == '0);
    end
  end

  assign sts_o.skip       = ovf_q || (len_q == '0);
  assign sts_o.last       = ({1'b0, pc_q} + LW'(1)) == len_q;
  assign sts_o.step_fault = step_fault;
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign match_o    = match_q;
  assign fault_o    = fault_out_q;

endmodule

FILE: sv/postfix_atom_record_filter.sv
// ---------------------------------------------------------------------------
// postfix_atom_record_filter
// Atom record filter running a stored postfix program on a truth stack.
// ---------------------------------------------------------------------------
// Each slave transaction carries an opcode in tuser: clear the program, append
// one term, or test one atom record. Clear and append give no result. A test
// has one step to start and fetch the first term, one step per stored term on
// the stack datapath (single-port program memory read, one term a cycle), and
// one step to load the result register; an overflowed or empty program goes
// straight from the start to the result load. The walk stops early at the
// first stack fault. A result waiting on the master side does not block new
// slave transactions; only the next test waits for the result register.
// Opcode 3 is accepted and ignored. No clearing pass after reset.
// ---------------------------------------------------------------------------
module postfix_atom_record_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata, low bit up: term_kind 6, term_text 32, term_low 16, term_high 16,
  // term_level 21, atom_name 32, atom_element 16, atom_residue_number 16,
  // atom_occupancy 21, atom_bfactor 21, atom_tags 48, zero pad 3
  input  logic [parf_pkg::IN_W-1:0]   s_axis_tdata_i,
  // tuser: opcode 2
  input  logic [parf_pkg::USER_W-1:0] s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tdata, low bit up: match 1, fault 1, zero pad 6
  output logic [parf_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import parf_pkg::*;

  term_t   term;
  atom_t   atom;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    match, fault;

  // unpack the slave transaction
  assign term.kind    = s_axis_tdata_i[5:0];
  assign term.text    = s_axis_tdata_i[37:6];
  assign term.low     = s_axis_tdata_i[53:38];
  assign term.high    = s_axis_tdata_i[69:54];
  assign term.level   = s_axis_tdata_i[90:70];
  assign atom.name    = s_axis_tdata_i[122:91];
  assign atom.element = s_axis_tdata_i[138:123];
  assign atom.resi    = s_axis_tdata_i[154:139];
  assign atom.occ     = s_axis_tdata_i[175:155];
  assign atom.bfac    = s_axis_tdata_i[196:176];
  assign atom.tags    = s_axis_tdata_i[244:197];

  parf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  parf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .term_i     (term),
    .atom_i     (atom),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .match_o    (match),
    .fault_o    (fault)
  );

  assign m_axis_tdata_o = {6'b0, fault, match};

endmodule

FILE: sv/parf_checker.sv
// ---------------------------------------------------------------------------
// parf_checker
// Port-level checks of the postfix atom record filter, bound to the top.
// ---------------------------------------------------------------------------
`include "postfix_atom_record_filter_assert.svh"

module parf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [parf_pkg::IN_W-1:0]   s_axis_tdata_i,
  input logic [parf_pkg::USER_W-1:0] s_axis_tuser_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [parf_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import parf_pkg::*;

  // stalled result holds
  `PARF_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // a faulted test never reports a match
  `PARF_ASSERT_NEVER(a_fault_no_match, m_axis_tvalid_o && m_axis_tdata_o[1] && m_axis_tdata_o[0], "match with fault")

  // a test transaction occupies the engine on the next cycle
  `PARF_ASSERT(a_eval_busy, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_EVAL |=> !s_axis_tready_o, "engine took a transaction during a test")

endmodule

bind postfix_atom_record_filter parf_checker u_parf_checker (.*);
